/* sv/psa_pkg.sv */
package psa_pkg;

  localparam int MAX_FRAGMENTS      = 16;
  localparam int MAX_FRAGMENT_CELLS = 16;
  localparam int KEY_BITS           = 32;

  localparam int STORE_DEPTH = MAX_FRAGMENTS * MAX_FRAGMENT_CELLS;
  localparam int FRAG_BITS   = $clog2(MAX_FRAGMENTS);
  localparam int OFF_BITS    = $clog2(MAX_FRAGMENT_CELLS);
  localparam int ADDR_BITS   = FRAG_BITS + OFF_BITS;
  localparam int IDX_BITS    = 9;
  localparam int CNT_BITS    = 5;
  localparam int CAP_BITS    = 9;
  localparam int OCC_BITS    = $clog2(MAX_FRAGMENT_CELLS + 1);
  localparam int ACT_BITS    = $clog2(MAX_FRAGMENTS + 1);

  typedef enum logic [2:0] {
    FUNC_SET         = 3'd0,
    FUNC_GET         = 3'd1,
    FUNC_DELETE      = 3'd2,
    FUNC_IS_SET      = 3'd3,
    FUNC_CONTAINS    = 3'd4,
    FUNC_CLEAR_ALL   = 3'd5,
    FUNC_READ_COUNTS = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    REG_FRAGMENT_COUNT     = 1'b0,
    REG_CELLS_PER_FRAGMENT = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                 in_range;
    logic [FRAG_BITS-1:0] frag;
    logic [OFF_BITS-1:0]  off;
  } split_t;

endpackage

/* sv/psa_split.sv */
module psa_split (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [psa_pkg::IDX_BITS-1:0]  cell_index,
  input  logic [psa_pkg::CNT_BITS-1:0]  cells_per_fragment,
  input  logic [psa_pkg::CAP_BITS-1:0]  capacity,
  output psa_pkg::split_t               split
);
  import psa_pkg::*;

  localparam int DIV_BITS = IDX_BITS + 1;

  logic [IDX_BITS-1:0] idx_q;
  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] trial;
  logic [FRAG_BITS-1:0] quo;

  always_ff @(posedge clk) begin
    if (load) begin
      idx_q <= cell_index;
    end
  end

  // Restoring division, one quotient bit per step. The quotient only matters
  // when the index is below capacity, so it never needs more than FRAG_BITS.
  always_comb begin
    rem   = DIV_BITS'(idx_q);
    trial = '0;
    quo   = '0;
    for (int i = FRAG_BITS - 1; i >= 0; i--) begin
      trial = DIV_BITS'(cells_per_fragment) << i;
      if (rem >= trial) begin
        rem    = rem - trial;
        quo[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      split.in_range <= (idx_q < capacity);
      split.frag     <= quo;
      split.off      <= rem[OFF_BITS-1:0];
    end
  end

endmodule

/* sv/paged_sparse_array.sv */
// Set, get, delete, is_set, clear_all and read_counts pass through the split,
// exec and response states, and the next command may be taken in the response
// cycle. contains_key scans all 256 store entries through the single read port
// in a scan state between exec and response. The index split stage and the
// update step set the path of the short commands; the one read port paces the scan.
// Reset (synchronous, active high) clears valid bits, fragment counts and totals;
// store contents stay undefined. The receiver cannot stall.
module paged_sparse_array (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    func,
  input  logic [psa_pkg::IDX_BITS-1:0]  cell_index,
  input  logic signed [31:0]            key_value,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [31:0]            read_value,
  output logic                          hit,
  output logic [psa_pkg::CAP_BITS-1:0]  stored_count,
  output logic [psa_pkg::CAP_BITS-1:0]  allocated_cells,
  output logic [psa_pkg::CAP_BITS-1:0]  capacity,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [psa_pkg::CNT_BITS-1:0]  cfg_data
);
  import psa_pkg::*;

  localparam int PROD_BITS = ACT_BITS + CNT_BITS;
  localparam logic [ADDR_BITS-1:0] SCAN_LAST = ADDR_BITS'(STORE_DEPTH - 1);

  state_t state, state_next;

  // Geometry registers, held already clamped to their legal range.
  logic [CNT_BITS-1:0] fragment_count;
  logic [CNT_BITS-1:0] cells_per_fragment;
  logic [CNT_BITS-1:0] cfg_clamped;

  // Array bookkeeping. The valid bits and the fragment counts are flops so that
  // clear_all and a geometry change can empty the array all at once. A
  // fragment is active exactly when its occupancy is nonzero.
  logic [STORE_DEPTH-1:0] cell_valid;
  logic [OCC_BITS-1:0]    fragment_occupancy [MAX_FRAGMENTS];
  logic [ACT_BITS-1:0]    active_fragments;
  logic [CAP_BITS-1:0]    total_filled;

  // Key store: one write port, one read port with registered data.
  logic [KEY_BITS-1:0] cell_store [STORE_DEPTH];
  logic [KEY_BITS-1:0] rd_data;
  logic                rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                wr_en;

  // Command registers.
  func_t               func_r;
  logic [KEY_BITS-1:0] key_r;
  split_t              split;
  logic [ADDR_BITS-1:0] addr;

  // Result registers.
  status_t status_r;
  logic    hit_r;
  logic    value_sel;
  status_t status_next;
  logic    hit_next;
  logic    value_sel_next;

  // Contains scan: one read issued per cycle, compared in the cycle after.
  logic [ADDR_BITS-1:0] scan_addr;
  logic                 scan_issue;
  logic                 scan_chk;

  logic accept;
  logic split_step;
  logic exec;
  logic [PROD_BITS-1:0] cap_prod;
  logic [PROD_BITS-1:0] alloc_prod;
  logic cell_hit;
  logic [OCC_BITS-1:0] occ_cur;

  assign accept   = start && !busy;
  assign addr     = {split.frag, split.off};
  assign cell_hit = cell_valid[addr];
  assign occ_cur  = fragment_occupancy[split.frag];

  assign cap_prod   = PROD_BITS'(fragment_count) * PROD_BITS'(cells_per_fragment);
  assign alloc_prod = PROD_BITS'(active_fragments) * PROD_BITS'(cells_per_fragment);

  // A register value of zero acts as one; anything above the maximum acts as
  // the maximum. Both registers share the same maximum here.
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = CNT_BITS'(1);
    end else if (cfg_index == REG_FRAGMENT_COUNT && cfg_data > CNT_BITS'(MAX_FRAGMENTS)) begin
      cfg_clamped = CNT_BITS'(MAX_FRAGMENTS);
    end else if (cfg_index == REG_CELLS_PER_FRAGMENT &&
                 cfg_data > CNT_BITS'(MAX_FRAGMENT_CELLS)) begin
      cfg_clamped = CNT_BITS'(MAX_FRAGMENT_CELLS);
    end
  end

  // The index split runs in its own stage: the command is captured at the
  // start edge and the fragment number and offset are registered in the split state.
  psa_split u_split (
    .clk                (clk),
    .load               (accept),
    .step               (split_step),
    .cell_index         (cell_index),
    .cells_per_fragment (cells_per_fragment),
    .capacity           (capacity),
    .split              (split)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_IDLE, ST_RESP: begin
        state_next = start ? ST_SPLIT : ST_IDLE;
      end
      ST_SPLIT: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = (func_r == FUNC_CONTAINS) ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        state_next = scan_issue ? ST_SCAN : ST_RESP;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State-driven controls. A word is presented in the response cycle, and the
  // next command may already be taken in that cycle since all updates are done.
  always_comb begin
    busy       = 1'b1;
    done       = 1'b0;
    split_step = 1'b0;
    exec       = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = addr;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SPLIT: begin
        split_step = 1'b1;
      end
      ST_EXEC: begin
        exec  = 1'b1;
        rd_en = (func_r == FUNC_GET);
      end
      ST_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = scan_addr;
      end
      ST_RESP: begin
        busy = 1'b0;
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign wr_en = exec && (func_r == FUNC_SET) && split.in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_store[addr] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= cell_store[rd_addr];
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func_t'(func);
      key_r  <= KEY_BITS'(key_value);
    end
  end

  // Geometry registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_count     <= CNT_BITS'(MAX_FRAGMENTS);
      cells_per_fragment <= CNT_BITS'(MAX_FRAGMENT_CELLS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAGMENT_COUNT:     fragment_count     <= cfg_clamped;
        REG_CELLS_PER_FRAGMENT: cells_per_fragment <= cfg_clamped;
        default:                fragment_count     <= fragment_count;
      endcase
    end
  end

  // Bookkeeping updates. Any register write empties the array, as does reset.
  always_ff @(posedge clk) begin
    if (rst || cfg_write || (exec && func_r == FUNC_CLEAR_ALL)) begin
      cell_valid       <= '0;
      active_fragments <= '0;
      total_filled     <= '0;
      for (int f = 0; f < MAX_FRAGMENTS; f++) begin
        fragment_occupancy[f] <= '0;
      end
    end else if (exec && split.in_range) begin
      if (func_r == FUNC_SET && !cell_hit) begin
        cell_valid[addr]               <= 1'b1;
        fragment_occupancy[split.frag] <= occ_cur + OCC_BITS'(1);
        total_filled                   <= total_filled + CAP_BITS'(1);
        if (occ_cur == '0) begin
          active_fragments <= active_fragments + ACT_BITS'(1);
        end
      end else if (func_r == FUNC_DELETE && cell_hit) begin
        cell_valid[addr]               <= 1'b0;
        fragment_occupancy[split.frag] <= occ_cur - OCC_BITS'(1);
        total_filled                   <= total_filled - CAP_BITS'(1);
        if (occ_cur == OCC_BITS'(1)) begin
          active_fragments <= active_fragments - ACT_BITS'(1);
        end
      end
    end
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_issue <= 1'b0;
      scan_chk   <= 1'b0;
    end else if (exec) begin
      scan_issue <= (func_r == FUNC_CONTAINS);
      scan_chk   <= 1'b0;
    end else if (state == ST_SCAN) begin
      scan_chk <= scan_issue && cell_valid[scan_addr];
      if (scan_addr == SCAN_LAST) begin
        scan_issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      scan_addr <= '0;
    end else if (state == ST_SCAN && scan_issue) begin
      scan_addr <= scan_addr + ADDR_BITS'(1);
    end
  end

  // Result fields. Only valid cells carry a key, and a valid cell always lies
  // in an active fragment inside the current geometry, so the scan needs no
  // other filter.
  always_comb begin
    status_next    = STATUS_OK;
    hit_next       = 1'b0;
    value_sel_next = 1'b0;
    case (func_r) inside
      FUNC_SET, FUNC_GET, FUNC_DELETE, FUNC_IS_SET: begin
        if (!split.in_range) begin
          status_next = STATUS_RANGE;
        end else if (func_r == FUNC_DELETE && !cell_hit) begin
          status_next = STATUS_EMPTY;
        end else if (func_r == FUNC_GET || func_r == FUNC_IS_SET) begin
          hit_next       = cell_hit;
          value_sel_next = (func_r == FUNC_GET) && cell_hit;
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_r  <= status_next;
      hit_r     <= hit_next;
      value_sel <= value_sel_next;
    end else if (state == ST_SCAN && scan_chk && rd_data == key_r) begin
      hit_r <= 1'b1;
    end
  end

  assign status          = status_r;
  assign read_value      = value_sel ? $signed(rd_data[31:0]) : 32'sd0;
  assign hit             = hit_r;
  assign stored_count    = total_filled;
  assign allocated_cells = alloc_prod[CAP_BITS-1:0];
  assign capacity        = cap_prod[CAP_BITS-1:0];

`ifndef NO_ASSERTIONS
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    total_filled <= capacity)
    else $error("filled cell count exceeds capacity");

  a_empty_only_delete: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_EMPTY |-> func_r == FUNC_DELETE)
    else $error("empty-cell status on a command other than delete");

  a_range_no_hit: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_RANGE |-> !hit && !value_sel)
    else $error("hit reported for an out-of-range index");

  a_set_marks_valid: assert property (@(posedge clk) disable iff (rst)
    exec && func_r == FUNC_SET && split.in_range && !cfg_write |=>
      cell_valid[$past(addr)])
    else $error("set did not mark its cell valid");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import psa_pkg::*;

  // The function code 7 has no name in the package; the block treats it like a
  // counter read, so it gets a name here to keep the stimulus readable.
  localparam logic [2:0] FUNC_UNUSED = 3'd7;

  // The watchdog ends the run after this many cycles in which no command is
  // taken, no word comes back and no register is written. The slowest correct
  // stretch is a key search behind a long sender gap.
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 50;
  localparam int N_PHASES    = 10;
  localparam int N_DIRECTED  = 25;

  // One result word, in the order of the result ports.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic        hit;
    logic [8:0]  stored;
    logic [8:0]  alloc;
    logic [8:0]  cap;
  } word_t;

  // One row of the directed table. Where typed is set, want holds the word
  // as it is read straight off the behavior; other rows use the predictor.
  typedef struct packed {
    logic [2:0]  code;
    logic [8:0]  idx;
    logic [31:0] key;
    logic        typed;
    word_t       want;
  } row_t;

  // The directed part runs in the reset geometry: 16 fragments of 16 cells.
  // It walks the extremes of index and key, every command, the range and
  // empty-delete errors, fragment release on the last delete, an overwrite,
  // the unused function code and a clear.
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{FUNC_READ_COUNTS, 9'd0,   32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd0, 9'd0,  9'd256}},
    '{FUNC_SET,         9'd0,   32'h8000_0000, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd1, 9'd16, 9'd256}},
    '{FUNC_SET,         9'd255, 32'h7FFF_FFFF, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_GET,         9'd0,   32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h8000_0000, 1'b1, 9'd2, 9'd32, 9'd256}},
    '{FUNC_GET,         9'd255, 32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h7FFF_FFFF, 1'b1, 9'd2, 9'd32, 9'd256}},
    '{FUNC_GET,         9'd1,   32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_GET,         9'd511, 32'h0000_0000, 1'b1,
      '{STATUS_RANGE, 32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_SET,         9'd256, 32'h0000_0005, 1'b1,
      '{STATUS_RANGE, 32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_DELETE,      9'd300, 32'h0000_0000, 1'b1,
      '{STATUS_RANGE, 32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_IS_SET,      9'd511, 32'h0000_0000, 1'b1,
      '{STATUS_RANGE, 32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_DELETE,      9'd17,  32'h0000_0000, 1'b1,
      '{STATUS_EMPTY, 32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_IS_SET,      9'd255, 32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b1, 9'd2, 9'd32, 9'd256}},
    '{FUNC_IS_SET,      9'd254, 32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_CONTAINS,    9'd0,   32'h7FFF_FFFF, 1'b0, '0},
    '{FUNC_CONTAINS,    9'd0,   32'h8000_0000, 1'b0, '0},
    '{FUNC_CONTAINS,    9'd511, 32'h0000_0000, 1'b0, '0},
    '{FUNC_SET,         9'd0,   32'hFFFF_FFFF, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_GET,         9'd0,   32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'hFFFF_FFFF, 1'b1, 9'd2, 9'd32, 9'd256}},
    '{FUNC_DELETE,      9'd0,   32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd1, 9'd16, 9'd256}},
    '{FUNC_DELETE,      9'd0,   32'h0000_0000, 1'b1,
      '{STATUS_EMPTY, 32'h0000_0000, 1'b0, 9'd1, 9'd16, 9'd256}},
    '{FUNC_SET,         9'd170, 32'h5555_5555, 1'b0, '0},
    '{FUNC_UNUSED,      9'd85,  32'hAAAA_AAAA, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd2, 9'd32, 9'd256}},
    '{FUNC_CLEAR_ALL,   9'd0,   32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd0, 9'd0,  9'd256}},
    '{FUNC_CONTAINS,    9'd0,   32'h7FFF_FFFF, 1'b0, '0},
    '{FUNC_GET,         9'd255, 32'h0000_0000, 1'b1,
      '{STATUS_OK,    32'h0000_0000, 1'b0, 9'd0, 9'd0,  9'd256}}
  };

  // Register settings for the random phases, raw as written to the port.
  // Zero must act as one and anything above 16 as 16.
  localparam logic [4:0] PHASE_FRAGS [8] = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd16,
                                             5'd3, 5'd16};
  localparam logic [4:0] PHASE_CELLS [8] = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd1,
                                             5'd7, 5'd16};

  // Keys that sit on the edges of the signed range, plus a few ordinary ones
  // so that sets overwrite and searches find equal keys.
  localparam logic [31:0] KEY_POOL [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                           32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_00FF,
                                           32'h1234_5678, 32'hC0FF_EE00};

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  func;
  logic [8:0]  cell_index;
  logic [31:0] key_value;
  logic        done;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic        hit;
  logic [8:0]  stored_count;
  logic [8:0]  allocated_cells;
  logic [8:0]  capacity;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [4:0]  cfg_data;

  paged_sparse_array i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .cell_index      (cell_index),
    .key_value       (key_value),
    .done            (done),
    .status          (status),
    .read_value      (read_value),
    .hit             (hit),
    .stored_count    (stored_count),
    .allocated_cells (allocated_cells),
    .capacity        (capacity),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Predictor state: a private copy of the array, its bookkeeping and the
  // geometry as the block sees it after clamping.
  logic [31:0] model_key [STORE_DEPTH];
  bit          model_valid [STORE_DEPTH];
  int          model_occ [MAX_FRAGMENTS];
  bit          model_live [MAX_FRAGMENTS];
  int          live_frags;
  int          filled_cells;
  int          frag_limit;
  int          cell_limit;

  word_t outcome_q [$];
  int    outcomes_due;
  int    fail_count;
  int    idle_cycles;

  // Handed from the driver to the monitor for the word being offered.
  bit    use_typed;
  word_t typed_want;

  // Recently stored indexes and keys, so that reads, deletes and searches
  // mostly land on filled cells instead of an empty array.
  logic [8:0]  stored_idx_q [$];
  logic [31:0] stored_key_q [$];

  function automatic int clamp_geometry(logic [4:0] raw, int top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  // Empties the array: valid bits, occupancies, live flags and totals.
  // The key store itself is left alone since it is only read where valid.
  function automatic void wipe_array();
    foreach (model_valid[i]) model_valid[i] = 1'b0;
    foreach (model_occ[i]) begin
      model_occ[i]  = 0;
      model_live[i] = 1'b0;
    end
    live_frags   = 0;
    filled_cells = 0;
  endfunction

  // Applies one command to the predictor state and returns the word that
  // the block should give for it.
  function automatic word_t command_outcome(logic [2:0] code, logic [8:0] idx,
                                            logic [31:0] key);
    int    frag;
    int    offset;
    int    slot;
    bit    fits;
    word_t w;
    frag   = idx / cell_limit;
    offset = idx % cell_limit;
    fits   = frag < frag_limit;
    slot   = fits ? frag * MAX_FRAGMENT_CELLS + offset : 0;
    w      = '0;
    case (code)
      FUNC_SET: begin
        if (!fits) begin
          w.status = STATUS_RANGE;
        end else begin
          // A fragment goes live on its first store.
          if (!model_live[frag]) begin
            model_live[frag] = 1'b1;
            live_frags++;
          end
          if (!model_valid[slot]) begin
            model_valid[slot] = 1'b1;
            model_occ[frag]++;
            filled_cells++;
          end
          model_key[slot] = key;
        end
      end
      FUNC_GET: begin
        if (!fits) begin
          w.status = STATUS_RANGE;
        end else if (model_valid[slot]) begin
          w.value = model_key[slot];
          w.hit   = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (!fits) begin
          w.status = STATUS_RANGE;
        end else if (!model_valid[slot]) begin
          w.status = STATUS_EMPTY;
        end else begin
          model_valid[slot] = 1'b0;
          model_occ[frag]--;
          filled_cells--;
          // The last delete in a fragment releases it.
          if (model_occ[frag] == 0) begin
            model_live[frag] = 1'b0;
            live_frags--;
          end
        end
      end
      FUNC_IS_SET: begin
        if (!fits) w.status = STATUS_RANGE;
        else w.hit = model_valid[slot];
      end
      FUNC_CONTAINS: begin
        // Only filled cells of live fragments inside the geometry count.
        for (int f = 0; f < frag_limit; f++) begin
          if (model_live[f]) begin
            for (int c = 0; c < cell_limit; c++) begin
              if (model_valid[f * MAX_FRAGMENT_CELLS + c] &&
                  model_key[f * MAX_FRAGMENT_CELLS + c] == key) w.hit = 1'b1;
            end
          end
        end
      end
      FUNC_CLEAR_ALL: wipe_array();
      default: ;
    endcase
    w.stored = 9'(filled_cells);
    w.alloc  = 9'(live_frags * cell_limit);
    w.cap    = 9'(frag_limit * cell_limit);
    return w;
  endfunction

  // Everything that happens at a clock edge is handled here, in one process:
  // a returning word is checked first, then a register write or a newly
  // taken command updates the predictor. Doing both in one place keeps the
  // order right when a word comes back at the same edge a command is taken.
  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (rst) begin
      frag_limit  = MAX_FRAGMENTS;
      cell_limit  = MAX_FRAGMENT_CELLS;
      wipe_array();
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (done) begin
        idle_cycles = 0;
        got = '{status, read_value, hit, stored_count, allocated_cells, capacity};
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word at %0t: status %0d value %h hit %0d",
                     $time, status, read_value, hit);
        end else begin
          want = outcome_q.pop_front();
          outcomes_due--;
          if (got.status !== want.status || got.value !== want.value ||
              got.hit !== want.hit || got.stored !== want.stored ||
              got.alloc !== want.alloc || got.cap !== want.cap) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result error at %0t (expected/actual): status %0d/%0d ",
                        "value %h/%h hit %0d/%0d stored %0d/%0d alloc %0d/%0d ",
                        "cap %0d/%0d"}, $time, want.status, got.status,
                       want.value, got.value, want.hit, got.hit, want.stored,
                       got.stored, want.alloc, got.alloc, want.cap, got.cap);
          end
        end
      end
      // A register write also empties the array.
      if (cfg_write) begin
        idle_cycles = 0;
        case (cfg_index)
          REG_FRAGMENT_COUNT:     frag_limit = clamp_geometry(cfg_data, MAX_FRAGMENTS);
          REG_CELLS_PER_FRAGMENT: cell_limit = clamp_geometry(cfg_data,
                                                              MAX_FRAGMENT_CELLS);
          default: ;
        endcase
        wipe_array();
      end
      if (start && !busy) begin
        idle_cycles = 0;
        want = command_outcome(func, cell_index, key_value);
        outcome_q.push_back(use_typed ? typed_want : want);
        outcomes_due++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("paged_sparse_array: mismatch");
        $finish;
      end
    end
  end

  // Offers one command word after an optional gap and returns once the
  // block has taken it. Inputs move only on falling edges.
  task automatic send_word(input logic [2:0] code, input logic [8:0] idx,
                           input logic [31:0] key, input bit typed,
                           input word_t want, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    func       <= code;
    cell_index <= idx;
    key_value  <= key;
    use_typed  = typed;
    typed_want = want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Registers are written only with the block idle: the command line is
  // dropped, every outstanding word is collected and the bench then waits.
  task automatic set_geometry(input logic [4:0] frags, input logic [4:0] cells);
    @(negedge clk);
    start <= 1'b0;
    while (outcomes_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAGMENT_COUNT;
    cfg_data  <= frags;
    @(negedge clk);
    cfg_index <= REG_CELLS_PER_FRAGMENT;
    cfg_data  <= cells;
    @(negedge clk);
    cfg_write <= 1'b0;
    stored_idx_q.delete();
    stored_key_q.delete();
  endtask

  initial begin
    logic [2:0]  code;
    logic [8:0]  idx;
    logic [31:0] key;
    logic [4:0]  frags;
    logic [4:0]  cells;
    int          pick;
    int          gap;
    int          room;
    bit          quiet;
    rst          = 1'b1;
    start        = 1'b0;
    func         = FUNC_READ_COUNTS;
    cell_index   = '0;
    key_value    = '0;
    cfg_write    = 1'b0;
    cfg_index    = REG_FRAGMENT_COUNT;
    cfg_data     = '0;
    use_typed    = 1'b0;
    typed_want   = '0;
    outcomes_due = 0;
    fail_count   = 0;
    idle_cycles  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, with a short random gap in front of some rows.
    for (int r = 0; r < N_DIRECTED; r++) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      send_word(DIRECTED[r].code, DIRECTED[r].idx, DIRECTED[r].key,
                DIRECTED[r].typed, DIRECTED[r].want, gap);
    end

    // Random phases, each in its own geometry. The last two geometries are
    // drawn at random over the whole 5-bit register range.
    for (int p = 0; p < N_PHASES; p++) begin
      frags = (p < 8) ? PHASE_FRAGS[p] : 5'($urandom_range(31));
      cells = (p < 8) ? PHASE_CELLS[p] : 5'($urandom_range(31));
      set_geometry(frags, cells);
      // Some phases run back to back so that commands follow each other
      // as fast as the block takes them.
      quiet = (p % 3 == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        room = frag_limit * cell_limit;
        pick = $urandom_range(99);
        if (pick < 35)      code = FUNC_SET;
        else if (pick < 55) code = FUNC_GET;
        else if (pick < 70) code = FUNC_DELETE;
        else if (pick < 80) code = FUNC_IS_SET;
        else if (pick < 87) code = FUNC_CONTAINS;
        else if (pick < 89) code = FUNC_CLEAR_ALL;
        else if (pick < 96) code = FUNC_READ_COUNTS;
        else                code = FUNC_UNUSED;
        // Mostly indexes inside the geometry, often ones already stored,
        // and now and then anything the port allows.
        if ($urandom_range(99) < 12)
          idx = 9'($urandom_range(511));
        else if (code != FUNC_SET && stored_idx_q.size() > 0 && $urandom_range(1) == 1)
          idx = stored_idx_q[$urandom_range(stored_idx_q.size() - 1)];
        else
          idx = 9'($urandom_range(room - 1));
        if (code == FUNC_CONTAINS && stored_key_q.size() > 0 && $urandom_range(99) < 60)
          key = stored_key_q[$urandom_range(stored_key_q.size() - 1)];
        else if ($urandom_range(1) == 1)
          key = KEY_POOL[$urandom_range(7)];
        else
          key = $urandom();
        if (code == FUNC_SET) begin
          stored_idx_q.push_back(idx);
          stored_key_q.push_back(key);
          if (stored_idx_q.size() > 24) begin
            void'(stored_idx_q.pop_front());
            void'(stored_key_q.pop_front());
          end
        end else if (code == FUNC_CLEAR_ALL) begin
          stored_idx_q.delete();
          stored_key_q.delete();
        end
        // Gaps: mostly none or short, a few long ones.
        pick = $urandom_range(99);
        if (quiet || pick < 55) gap = 0;
        else if (pick < 88)     gap = $urandom_range(1, 3);
        else                    gap = $urandom_range(10, 40);
        send_word(code, idx, key, 1'b0, '0, gap);
      end
    end

    // Drain: drop the command line, collect every word, then keep watching
    // for stray result words.
    @(negedge clk);
    start <= 1'b0;
    while (outcomes_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("paged_sparse_array: match");
    end else begin
      $display("paged_sparse_array: mismatch");
    end
    $finish;
  end

endmodule
